FILE: rtl/buddy_pkg.sv
package buddy_pkg;

    localparam int REQ_BITS   = 1;
    localparam int OWNER_W    = 8;
    localparam int SIZE_BITS  = 5;
    localparam int ADDR_BITS  = 4;
    localparam int ORDER_BITS = 3;
    localparam int STAT_BITS  = 2;

    localparam logic [REQ_BITS-1:0] REQ_ALLOC = 1'b0;
    localparam logic [REQ_BITS-1:0] REQ_FREE  = 1'b1;

    localparam logic [STAT_BITS-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_BITS-1:0] ST_NO_MEM    = 2'd1;
    localparam logic [STAT_BITS-1:0] ST_BAD_SIZE  = 2'd2;
    localparam logic [STAT_BITS-1:0] ST_NOT_FOUND = 2'd3;

    localparam int IN_BYTES  = (REQ_BITS + OWNER_W + SIZE_BITS + 7) / 8;
    localparam int OUT_BYTES = (ADDR_BITS + ORDER_BITS + STAT_BITS + 7) / 8;

    typedef struct packed {
        logic [ADDR_BITS-1:0]  addr;
        logic [ORDER_BITS-1:0] order;
        logic [STAT_BITS-1:0]  status;
    } t_result;

endpackage

FILE: rtl/buddy_allocator_16_units_top.sv
// Buddy allocator over a table of memory units held in one synchronous RAM
// (start flag, order, used flag, owner per unit). Each transaction is either
// an allocate (owner, size 1..2^MAX_ORDER) or a free (owner) and returns one
// result: start unit, order and status. Transactions are handled one at a
// time by a sequencer that walks the unit table through the single RAM port:
// one scan of MEM_UNITS entries (one read per cycle), then one write per
// split level, or one read and up to three writes per merge level, with up to
// MAX_ORDER merge levels per free. The sequencer waits in its output state
// while an earlier result is still held by the receiver. After reset a
// clearing pass over all MEM_UNITS entries rebuilds the table before the
// first transaction is taken. A finished result sits in an output
// register while the next transaction may already be accepted.
module buddy_allocator_16_units_top #(
    parameter int MEM_UNITS  = 16,
    parameter int MAX_ORDER  = 4,
    parameter int OWNER_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] req_type, [8:1] owner_id, [13:9] request_size, zero pad
    input  logic [15:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] block_addr, [6:4] block_order, [8:7] status, zero pad
    output logic [15:0] m_axis_tdata
);
    import buddy_pkg::*;

    localparam int AW  = $clog2(MEM_UNITS);
    localparam int CW  = $clog2(MEM_UNITS + 1);
    localparam int OW  = $clog2(MAX_ORDER + 1);
    localparam int FW  = $clog2(MEM_UNITS + 1) + 1;
    localparam int EW  = 1 + OW + 1 + OWNER_BITS;
    localparam int BLK = 1 << MAX_ORDER;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_DEC   = 4'd3;
    localparam logic [3:0] S_SPLIT = 4'd4;
    localparam logic [3:0] S_TAKE  = 4'd5;
    localparam logic [3:0] S_FREE  = 4'd6;
    localparam logic [3:0] S_MRD   = 4'd7;
    localparam logic [3:0] S_MCHK  = 4'd8;
    localparam logic [3:0] S_MWR   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_WAIT  = 4'd11;

    // entry: {start, order, used, owner}
    logic [EW-1:0] mem [MEM_UNITS];
    logic [EW-1:0] r_rd;
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [EW-1:0] mem_wd;

    logic [3:0]            r_st, n_st;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [AW-1:0]         r_pa, n_pa;
    logic                  r_req, n_req;
    logic [OWNER_BITS-1:0] r_own, n_own;
    logic [SIZE_BITS-1:0]  r_size, n_size;
    logic [OW-1:0]         r_need, n_need;
    logic                  r_found, n_found;
    logic [AW-1:0]         r_best, n_best;
    logic [OW-1:0]         r_bord, n_bord;
    logic [FW-1:0]         r_sum, n_sum;
    t_result               r_res, n_res;
    logic                  r_mv, n_mv;
    t_result               r_out;

    logic          e_start, e_used;
    logic [OW-1:0] e_ord;
    logic [OWNER_BITS-1:0] e_own;
    logic [AW-1:0] prev_a, buddy;
    logic [AW:0]   upper;
    logic          acc;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[mem_ra];
    end

    assign e_start = r_rd[EW-1];
    assign e_ord   = r_rd[EW-2 -: OW];
    assign e_used  = r_rd[OWNER_BITS];
    assign e_own   = r_rd[OWNER_BITS-1:0];
    assign prev_a  = AW'(r_cnt - CW'(1));
    assign buddy   = r_pa ^ AW'((AW+1)'(1) << r_bord);
    assign upper   = (AW+1)'(r_best) + ((AW+1)'(1) << (r_bord - OW'(1)));

    assign s_axis_tready = (r_st == S_IDLE);
    assign acc = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_pa = r_pa; n_req = r_req; n_own = r_own;
        n_size = r_size; n_need = r_need; n_found = r_found; n_best = r_best;
        n_bord = r_bord; n_sum = r_sum; n_res = r_res; n_mv = r_mv;
        mem_we = 1'b0; mem_wa = '0; mem_wd = '0; mem_ra = '0;
        if (r_mv && m_axis_tready) begin
            n_mv = 1'b0;
        end
        unique case (r_st)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = AW'(r_cnt);
                mem_wd = ((r_cnt % BLK) == 0 &&
                          (CW+1)'(r_cnt) + (CW+1)'(BLK) <= (CW+1)'(MEM_UNITS))
                    ? {1'b1, OW'(MAX_ORDER), 1'b0, OWNER_BITS'(0)} : '0;
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(MEM_UNITS - 1)) begin
                    n_st = S_IDLE;
                end
            end
            S_IDLE: begin
                if (acc) begin
                    n_req   = s_axis_tdata[0];
                    n_own   = OWNER_BITS'(s_axis_tdata[8:1]);
                    n_size  = s_axis_tdata[13:9];
                    n_need  = '0;
                    for (int k = 1; k <= MAX_ORDER; k++) begin
                        if ((32'd1 << (k - 1)) < 32'(s_axis_tdata[13:9])) begin
                            n_need = OW'(k);
                        end
                    end
                    n_found = 1'b0;
                    n_sum   = '0;
                    n_cnt   = '0;
                    n_st    = S_SCAN;
                end
            end
            S_SCAN: begin
                // read issued at r_cnt, data of r_cnt-1 present
                mem_ra = AW'(r_cnt);
                if (r_cnt != '0) begin
                    if (e_start && !e_used) begin
                        n_sum = r_sum + FW'((CW+1)'(1) << e_ord);
                        if (r_req == REQ_ALLOC && e_ord >= r_need &&
                            (!r_found || e_ord < r_bord)) begin
                            n_found = 1'b1; n_best = prev_a; n_bord = e_ord;
                        end
                    end
                    if (r_req == REQ_FREE && !r_found && e_start && e_used
                        && e_own == r_own) begin
                        n_found = 1'b1; n_best = prev_a; n_bord = e_ord;
                    end
                end
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(MEM_UNITS)) begin
                    n_st = S_DEC;
                end
            end
            S_DEC: begin
                n_st = S_OUT;
                if (r_req == REQ_FREE) begin
                    if (!r_found) begin
                        n_res = '{addr: '0, order: '0, status: ST_NOT_FOUND};
                    end else begin
                        n_res = '{addr: ADDR_BITS'(r_best), order: ORDER_BITS'(r_bord),
                                  status: ST_OK};
                        n_pa = r_best;
                        n_st = S_FREE;
                    end
                end else if (r_size == '0 || 32'(r_size) > BLK) begin
                    n_res = '{addr: '0, order: '0, status: ST_BAD_SIZE};
                end else if (r_sum < FW'(r_size) || !r_found) begin
                    n_res = '{addr: '0, order: '0, status: ST_NO_MEM};
                end else begin
                    n_st = S_SPLIT;
                end
            end
            S_SPLIT: begin
                if (r_bord > r_need) begin
                    n_bord = r_bord - OW'(1);
                    if (upper < (AW+1)'(MEM_UNITS)) begin
                        mem_we = 1'b1;
                        mem_wa = AW'(upper);
                        mem_wd = {1'b1, OW'(r_bord - OW'(1)), 1'b0, OWNER_BITS'(0)};
                    end
                end else begin
                    n_st = S_TAKE;
                end
            end
            S_TAKE: begin
                mem_we = 1'b1;
                mem_wa = r_best;
                mem_wd = {1'b1, r_bord, 1'b1, r_own};
                n_res = '{addr: ADDR_BITS'(r_best), order: ORDER_BITS'(r_bord),
                          status: ST_OK};
                n_st = S_OUT;
            end
            S_FREE: begin
                mem_we = 1'b1;
                mem_wa = r_pa;
                mem_wd = {1'b1, r_bord, 1'b0, OWNER_BITS'(0)};
                n_st = S_MRD;
            end
            S_MRD: begin
                if (r_bord >= OW'(MAX_ORDER) ||
                    (AW+1)'(buddy) >= (AW+1)'(MEM_UNITS) ||
                    (r_pa & AW'((AW+1)'(1) << r_bord)) != 0 &&
                    (AW+1)'(r_pa) >= (AW+1)'(MEM_UNITS)) begin
                    n_st = S_OUT;
                end else begin
                    mem_ra = buddy;
                    n_st = S_MCHK;
                end
            end
            S_MCHK: begin
                if (e_start && !e_used && e_ord == r_bord) begin
                    mem_we = 1'b1;
                    mem_wa = buddy;
                    mem_wd = '0;
                    n_st = S_MWR;
                end else begin
                    n_st = S_OUT;
                end
            end
            S_MWR: begin
                mem_we = 1'b1;
                mem_wa = r_pa;
                mem_wd = '0;
                // low half written as the merged block in S_WAIT
                n_pa = r_pa & buddy;
                n_bord = r_bord + OW'(1);
                n_st = S_WAIT;
            end
            S_WAIT: begin
                mem_we = 1'b1;
                mem_wa = r_pa;
                mem_wd = {1'b1, r_bord, 1'b0, OWNER_BITS'(0)};
                n_st = S_MRD;
            end
            S_OUT: begin
                if (!r_mv || m_axis_tready) begin
                    n_mv = 1'b1;
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLEAR;
            r_cnt <= '0;
            r_mv <= 1'b0;
        end else begin
            r_st <= n_st;
            r_cnt <= n_cnt;
            r_mv <= n_mv;
        end
        r_pa <= n_pa; r_req <= n_req; r_own <= n_own; r_size <= n_size;
        r_need <= n_need; r_found <= n_found; r_best <= n_best; r_bord <= n_bord;
        r_sum <= n_sum; r_res <= n_res;
        if (r_st == S_OUT && (!r_mv || m_axis_tready)) begin
            r_out <= r_res;
        end
    end

    assign m_axis_tvalid = r_mv;
    assign m_axis_tdata  = {7'd0, r_out.status, r_out.order, r_out.addr};

endmodule

FILE: rtl/buddy_chk.sv
module buddy_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);
    import buddy_pkg::*;

    // a transaction is never taken on the cycle after one was taken
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("back to back accept");

    // failed requests report zero address and order
    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[8:7] != ST_OK) |-> m_axis_tdata[6:0] == '0)
        else $error("failed result not zeroed");

    // order never above max
    a_ord: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[6:4] <= 3'd4)
        else $error("order out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

endmodule

bind buddy_allocator_16_units_top buddy_chk u_chk (.*);

FILE: tb/buddy_allocator_16_units_top_tb.sv
module buddy_allocator_16_units_top_tb;
    import buddy_pkg::*;

    localparam int N_UNITS    = 16;
    localparam int TOP_ORDER  = 4;
    localparam int N_RANDOM   = 1330;
    localparam int DRAIN_WAIT = 200;
    localparam int CYCLE_CAP  = 600000;

    typedef struct packed {
        logic [REQ_BITS-1:0]  req;
        logic [OWNER_W-1:0]   owner;
        logic [SIZE_BITS-1:0] size;
    } t_request;

    typedef struct {
        t_request rq;
        bit       typed;
        t_result  res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    buddy_allocator_16_units_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // allocator state mirror
    bit       blk_start [N_UNITS];
    bit [2:0] blk_order [N_UNITS];
    bit       blk_used  [N_UNITS];
    bit [7:0] blk_owner [N_UNITS];

    t_result  pending_results[$];
    t_row     rows[$];
    int       errors;
    int       cycles;
    bit       stall_pattern;
    bit [7:0] live_owners[$];
    bit       directed_phase;
    int       row_acc;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic void alloc_reset();
        for (int a = 0; a < N_UNITS; a++) begin
            blk_start[a] = (a % (1 << TOP_ORDER)) == 0;
            blk_order[a] = blk_start[a] ? 3'(TOP_ORDER) : 3'd0;
            blk_used[a]  = 1'b0;
            blk_owner[a] = 8'd0;
        end
    endfunction

    function automatic t_result alloc_predict(t_request rq);
        t_result r;
        int need, total, best, best_ord, addr, ord, buddy, low;
        bit found;
        r = '0;
        need = 0;
        total = 0;
        best = 0;
        best_ord = 0;
        found = 1'b0;
        if (rq.req == REQ_ALLOC) begin
            if (rq.size == 0 || rq.size > (1 << TOP_ORDER)) begin
                r.status = ST_BAD_SIZE;
                return r;
            end
            while ((1 << need) < rq.size) need++;
            for (int a = 0; a < N_UNITS; a++)
                if (blk_start[a] && !blk_used[a]) total += 1 << blk_order[a];
            if (total < rq.size) begin
                r.status = ST_NO_MEM;
                return r;
            end
            for (int a = 0; a < N_UNITS; a++)
                if (blk_start[a] && !blk_used[a] && blk_order[a] >= need &&
                    (!found || blk_order[a] < best_ord)) begin
                    found = 1'b1;
                    best = a;
                    best_ord = blk_order[a];
                end
            if (!found) begin
                r.status = ST_NO_MEM;
                return r;
            end
            while (best_ord > need) begin
                best_ord--;
                if (best + (1 << best_ord) < N_UNITS) begin
                    blk_start[best + (1 << best_ord)] = 1'b1;
                    blk_order[best + (1 << best_ord)] = 3'(best_ord);
                    blk_used[best + (1 << best_ord)]  = 1'b0;
                    blk_owner[best + (1 << best_ord)] = 8'd0;
                end
            end
            blk_order[best] = 3'(best_ord);
            blk_used[best]  = 1'b1;
            blk_owner[best] = rq.owner;
            r.addr   = 4'(best);
            r.order  = 3'(best_ord);
            r.status = ST_OK;
            return r;
        end
        addr = 0;
        for (int a = N_UNITS - 1; a >= 0; a--)
            if (blk_start[a] && blk_used[a] && blk_owner[a] == rq.owner) begin
                found = 1'b1;
                addr = a;
            end
        if (!found) begin
            r.status = ST_NOT_FOUND;
            return r;
        end
        ord = blk_order[addr];
        r.addr   = 4'(addr);
        r.order  = 3'(ord);
        r.status = ST_OK;
        blk_used[addr]  = 1'b0;
        blk_owner[addr] = 8'd0;
        while (ord < TOP_ORDER) begin
            buddy = addr ^ (1 << ord);
            if (buddy >= N_UNITS || !blk_start[buddy] || blk_used[buddy] ||
                blk_order[buddy] != ord)
                break;
            low = addr < buddy ? addr : buddy;
            blk_start[addr] = 1'b0;
            blk_order[addr] = 3'd0;
            blk_start[buddy] = 1'b0;
            blk_order[buddy] = 3'd0;
            ord++;
            addr = low;
            blk_start[addr] = 1'b1;
            blk_order[addr] = 3'(ord);
        end
        return r;
    endfunction

    function automatic t_request mk(bit [0:0] req, bit [7:0] owner, bit [4:0] size);
        t_request rq;
        rq.req = req;
        rq.owner = owner;
        rq.size = size;
        return rq;
    endfunction

    task automatic add_row(t_request rq, bit typed, bit [3:0] addr, bit [2:0] ord,
                           bit [1:0] st);
        t_row row;
        row.rq = rq;
        row.typed = typed;
        row.res.addr = addr;
        row.res.order = ord;
        row.res.status = st;
        rows.push_back(row);
    endtask

    // one transaction on the slave side
    task automatic send_request(t_request rq);
        s_axis_tdata  <= {2'b00, rq.size, rq.owner, rq.req};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic random_gap();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic t_request random_request();
        t_request rq;
        int pick, idx;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            rq = mk(REQ_ALLOC, 8'($urandom_range(0, 15)), 5'($urandom_range(1, 8)));
            if ($urandom_range(0, 9) == 0) rq.size = 5'($urandom_range(9, 16));
            if ($urandom_range(0, 19) == 0) rq.owner = 8'($urandom);
        end else if (pick < 90 && live_owners.size() > 0) begin
            idx = $urandom_range(0, live_owners.size() - 1);
            rq = mk(REQ_FREE, live_owners[idx], 5'($urandom));
            live_owners.delete(idx);
        end else begin
            rq = mk(1'($urandom), 8'($urandom), 5'($urandom));
        end
        return rq;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.addr   = m_axis_tdata[3:0];
            got.order  = m_axis_tdata[6:4];
            got.status = m_axis_tdata[8:7];
            if (pending_results.size() == 0) begin
                $error("unexpected result %h", m_axis_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.addr !== want.addr) begin
                    $error("block_addr expected %0d got %0d", want.addr, got.addr);
                    errors++;
                end
                if (got.order !== want.order) begin
                    $error("block_order expected %0d got %0d", want.order, got.order);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $error("status expected %0d got %0d", want.status, got.status);
                    errors++;
                end
                if (m_axis_tdata[15:9] !== 7'd0) begin
                    $error("pad expected 0 got %h", m_axis_tdata[15:9]);
                    errors++;
                end
            end
        end
    end

    // expectations are queued when the request transaction is accepted;
    // typed table rows use their typed result, the mirror still advances
    always @(posedge i_clk) begin
        t_request rq;
        t_result  r;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            rq.req   = s_axis_tdata[0];
            rq.owner = s_axis_tdata[8:1];
            rq.size  = s_axis_tdata[13:9];
            r = alloc_predict(rq);
            if (directed_phase) begin
                if (rows[row_acc].typed) r = rows[row_acc].res;
                row_acc++;
            end
            pending_results.push_back(r);
            if (rq.req == REQ_ALLOC && r.status == ST_OK) live_owners.push_back(rq.owner);
        end
    end

    // receiver stalls: alternating always-ready and randomly stalling stretches
    always @(posedge i_clk) begin
        if ($urandom_range(0, 63) == 0) stall_pattern <= ~stall_pattern;
        if (stall_pattern)
            m_axis_tready <= ($urandom_range(0, 2) != 0);
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("buddy_allocator_16_units_top_tb NOT OK");
            $finish;
        end
    end

    initial begin
        errors = 0;
        cycles = 0;
        stall_pattern = 1'b0;
        directed_phase = 1'b1;
        row_acc = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        alloc_reset();

        // directed rows
        add_row(mk(REQ_FREE,  8'd1,   5'd0),  1, 0, 0, ST_NOT_FOUND);
        add_row(mk(REQ_ALLOC, 8'd1,   5'd0),  1, 0, 0, ST_BAD_SIZE);
        add_row(mk(REQ_ALLOC, 8'd1,   5'd17), 1, 0, 0, ST_BAD_SIZE);
        add_row(mk(REQ_ALLOC, 8'd1,   5'd31), 1, 0, 0, ST_BAD_SIZE);
        add_row(mk(REQ_ALLOC, 8'd255, 5'd16), 1, 0, 4, ST_OK);
        add_row(mk(REQ_ALLOC, 8'd2,   5'd1),  1, 0, 0, ST_NO_MEM);
        add_row(mk(REQ_FREE,  8'd255, 5'd31), 1, 0, 4, ST_OK);
        add_row(mk(REQ_ALLOC, 8'd0,   5'd1),  1, 0, 0, ST_OK);
        add_row(mk(REQ_ALLOC, 8'd0,   5'd3),  0, 0, 0, ST_OK);
        add_row(mk(REQ_ALLOC, 8'd7,   5'd5),  0, 0, 0, ST_OK);
        add_row(mk(REQ_ALLOC, 8'd7,   5'd2),  0, 0, 0, ST_OK);
        add_row(mk(REQ_ALLOC, 8'd9,   5'd1),  0, 0, 0, ST_OK);
        add_row(mk(REQ_ALLOC, 8'd9,   5'd8),  0, 0, 0, ST_OK);
        add_row(mk(REQ_FREE,  8'd7,   5'd0),  0, 0, 0, ST_OK);
        add_row(mk(REQ_ALLOC, 8'd10,  5'd8),  0, 0, 0, ST_OK);
        add_row(mk(REQ_FREE,  8'd0,   5'd0),  0, 0, 0, ST_OK);
        add_row(mk(REQ_FREE,  8'd0,   5'd0),  0, 0, 0, ST_OK);
        add_row(mk(REQ_FREE,  8'd9,   5'd0),  0, 0, 0, ST_OK);
        add_row(mk(REQ_FREE,  8'd7,   5'd0),  0, 0, 0, ST_OK);
        add_row(mk(REQ_FREE,  8'd9,   5'd0),  0, 0, 0, ST_OK);
        add_row(mk(REQ_FREE,  8'd9,   5'd0),  0, 0, 0, ST_OK);
        add_row(mk(REQ_ALLOC, 8'd3,   5'd16), 0, 0, 0, ST_OK);
        add_row(mk(REQ_FREE,  8'd3,   5'd0),  0, 0, 0, ST_OK);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // walk the table
        foreach (rows[i]) begin
            send_request(rows[i].rq);
            random_gap();
        end

        // hold off until all expected results are back
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        directed_phase = 1'b0;

        for (int n = 0; n < N_RANDOM; n++) begin
            send_request(random_request());
            random_gap();
            if (n == N_RANDOM / 2) begin
                s_axis_tvalid <= 1'b0;
                do @(posedge i_clk); while (pending_results.size() != 0);
            end
        end
        s_axis_tvalid <= 1'b0;

        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (errors == 0)
            $display("buddy_allocator_16_units_top_tb OK");
        else
            $display("buddy_allocator_16_units_top_tb NOT OK");
        $finish;
    end

endmodule

FILE: buddy_allocator_16_units_top.f
rtl/buddy_pkg.sv
rtl/buddy_allocator_16_units_top.sv
rtl/buddy_chk.sv
tb/buddy_allocator_16_units_top_tb.sv
